>>> src/wmdp_pkg.sv
// ----------------------------------------------------------------------------
// wmdp_pkg
// Shared types, widths and codes for the window match density painter.
// ----------------------------------------------------------------------------
`default_nettype none

package wmdp_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int WIN_ADDR_W = $clog2(MAX_WINDOW);
    localparam int WS_W       = WIN_ADDR_W + 1;
    localparam int SCORE_W    = 10;
    localparam int COORD_BITS = 28;
    localparam int SEEN_W     = 20;
    localparam int BAD_W      = 24;
    localparam int CFG_DATA_W = 10;

    localparam logic [WS_W-1:0]           WINDOW_SIZE_RST = WS_W'(200);
    localparam logic signed [SCORE_W-1:0] MIN_SCORE_RST   = SCORE_W'(190);

    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_MIN_SCORE   = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_PAINT   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] position;
        logic                  is_match;
        logic                  first_of_alignment;
        logic                  last_of_alignment;
    } item_t;

    typedef struct packed {
        kind_t                 kind;
        logic [COORD_BITS-1:0] paint_start;
        logic [WS_W-1:0]       paint_length;
        logic                  suspect_found;
        logic [BAD_W-1:0]      bad_count;
        logic [COORD_BITS-1:0] first_marked;
        logic [COORD_BITS:0]   last_marked;
        logic                  end_of_run;
    } result_t;

    typedef struct packed {
        logic    paint_hit;
        logic    summ_hit;
        result_t paint;
        result_t summ;
    } step_out_t;

    // window size clamped to 1 .. MAX_WINDOW
    function automatic logic [WS_W-1:0] eff_window(input logic [WS_W-1:0] ws);
        logic [WS_W-1:0] w;
        w = ws;
        if (w == '0)
        begin
            w = WS_W'(1);
        end
        else if (w > WS_W'(MAX_WINDOW))
        begin
            w = WS_W'(MAX_WINDOW);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/wmdp_window.sv
// ----------------------------------------------------------------------------
// wmdp_window
// Circular delay memory of match bits; returns the bit that leaves the window.
// ----------------------------------------------------------------------------
`default_nettype none

module wmdp_window (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic                       wr_bit,
    input  wire logic [wmdp_pkg::WS_W-1:0]  win_size,
    output logic                            old_bit
);

    logic                              mem [wmdp_pkg::MAX_WINDOW];
    logic [wmdp_pkg::WIN_ADDR_W-1:0]   wptr_reg;
    logic [wmdp_pkg::WIN_ADDR_W-1:0]   wptr_next;
    logic [wmdp_pkg::WIN_ADDR_W-1:0]   rd_addr;
    logic                              old_reg;

    // a full-size window wraps onto the write address: read-first gives the old bit
    assign rd_addr   = wptr_reg - win_size[wmdp_pkg::WIN_ADDR_W-1:0];
    assign wptr_next = wptr_reg + 1'b1;
    assign old_bit   = old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
        end
        else if (wr_en)
        begin
            wptr_reg <= wptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            old_reg       <= mem[rd_addr];
            mem[wptr_reg] <= wr_bit;
        end
    end

endmodule

`default_nettype wire

>>> src/wmdp_score.sv
// ----------------------------------------------------------------------------
// wmdp_score
// Running window score, run tracking and paint / summary generation.
// ----------------------------------------------------------------------------
`default_nettype none

module wmdp_score (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire wmdp_pkg::item_t                     item,
    input  wire logic                                old_bit,
    input  wire logic [wmdp_pkg::WS_W-1:0]           win_size,
    input  wire logic signed [wmdp_pkg::SCORE_W-1:0] min_score,
    output wmdp_pkg::step_out_t                      step
);

    localparam int SWX = wmdp_pkg::SCORE_W + 2;
    localparam int CB  = wmdp_pkg::COORD_BITS;
    localparam int SW  = wmdp_pkg::SEEN_W;
    localparam int BW  = wmdp_pkg::BAD_W;
    localparam int WW  = wmdp_pkg::WS_W;
    localparam logic signed [SWX-1:0] SMAX = SWX'((1 <<< (wmdp_pkg::SCORE_W - 1)) - 1);
    localparam logic signed [SWX-1:0] SMIN = SWX'(-(1 <<< (wmdp_pkg::SCORE_W - 1)));
    localparam logic signed [SWX-1:0] ONE  = SWX'(1);

    logic signed [wmdp_pkg::SCORE_W-1:0] score_reg, score_next, score_cur;
    logic [SW-1:0]                       seen_reg, seen_next, seen_cur;
    logic [CB-1:0]                       origin_reg, origin_next, origin_cur;
    logic                                run_reg, run_next, run_cur;
    logic                                any_reg, any_next, any_cur;
    logic [CB-1:0]                       fm_reg, fm_next, fm_cur;
    logic [CB:0]                         lm_reg, lm_next, lm_cur;
    logic [BW-1:0]                       bad_reg, bad_next, bad_cur;

    logic signed [SWX-1:0] sum_w;
    logic [SW:0]           i_inc;
    logic [SW:0]           ws_x;
    logic                  at_first;
    logic                  past_win;
    logic                  qual;
    logic [CB:0]           origin_plus_i;
    logic [CB-1:0]         new_run_start;
    logic [WW-1:0]         add_n;
    logic [BW:0]           bad_sum;
    logic                  found;

    always_comb
    begin
        // a new alignment starts from cleared counters
        if (item.first_of_alignment)
        begin
            score_cur  = '0;
            seen_cur   = '0;
            origin_cur = item.position;
            run_cur    = 1'b0;
            any_cur    = 1'b0;
            fm_cur     = '0;
            lm_cur     = '0;
            bad_cur    = '0;
        end
        else
        begin
            score_cur  = score_reg;
            seen_cur   = seen_reg;
            origin_cur = origin_reg;
            run_cur    = run_reg;
            any_cur    = any_reg;
            fm_cur     = fm_reg;
            lm_cur     = lm_reg;
            bad_cur    = bad_reg;
        end

        i_inc    = {1'b0, seen_cur} + 1'b1;
        ws_x     = (SW + 1)'(win_size);
        at_first = (i_inc == ws_x);
        past_win = ({1'b0, seen_cur} >= ws_x);

        sum_w = SWX'(score_cur) + (item.is_match ? ONE : -ONE);
        if (past_win)
        begin
            sum_w = sum_w - (old_bit ? ONE : -ONE);
        end
        if (sum_w > SMAX)
        begin
            sum_w = SMAX;
        end
        else if (sum_w < SMIN)
        begin
            sum_w = SMIN;
        end
        score_next = $signed(sum_w[wmdp_pkg::SCORE_W-1:0]);
        qual       = (score_next >= min_score);

        seen_next     = (seen_cur != '1) ? seen_cur + 1'b1 : seen_cur;
        origin_plus_i = {1'b0, origin_cur} + (CB + 1)'(seen_cur);
        new_run_start = origin_plus_i[CB-1:0] - CB'(win_size) + 1'b1;

        origin_next = origin_cur;
        run_next    = run_cur;
        any_next    = any_cur;
        fm_next     = fm_cur;
        lm_next     = lm_cur;
        add_n       = '0;

        step = '0;
        step.paint.kind       = wmdp_pkg::KIND_PAINT;
        step.paint.end_of_run = !item.last_of_alignment;
        step.summ.kind        = wmdp_pkg::KIND_SUMMARY;
        step.summ.end_of_run  = 1'b1;

        if (at_first)
        begin
            if (qual)
            begin
                step.paint_hit          = 1'b1;
                step.paint.paint_start  = origin_cur;
                step.paint.paint_length = win_size;
                add_n    = win_size;
                any_next = 1'b1;
                run_next = 1'b1;
                fm_next  = origin_cur;
                // recorded one past the end of the window
                lm_next  = {1'b0, origin_cur} + (CB + 1)'(win_size);
            end
            else
            begin
                run_next = 1'b0;
            end
        end
        else if (past_win)
        begin
            if (qual)
            begin
                step.paint_hit = 1'b1;
                if (run_cur)
                begin
                    step.paint.paint_start  = origin_plus_i[CB-1:0];
                    step.paint.paint_length = WW'(1);
                    add_n = WW'(1);
                end
                else
                begin
                    // new run repaints the whole window, counted again
                    step.paint.paint_start  = new_run_start;
                    step.paint.paint_length = win_size;
                    add_n = win_size;
                    if (!any_cur)
                    begin
                        fm_next = new_run_start;
                    end
                end
                lm_next  = origin_plus_i;
                any_next = 1'b1;
                run_next = 1'b1;
            end
            else
            begin
                run_next = 1'b0;
            end
        end

        bad_sum  = {1'b0, bad_cur} + (BW + 1)'(add_n);
        bad_next = bad_sum[BW] ? '1 : bad_sum[BW-1:0];

        found = any_next && (i_inc >= ws_x);
        step.summ_hit = item.last_of_alignment;
        if (found)
        begin
            step.summ.suspect_found = 1'b1;
            step.summ.bad_count     = bad_next;
            step.summ.first_marked  = fm_next;
            step.summ.last_marked   = lm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg  <= '0;
            seen_reg   <= '0;
            origin_reg <= '0;
            run_reg    <= 1'b0;
            any_reg    <= 1'b0;
            fm_reg     <= '0;
            lm_reg     <= '0;
            bad_reg    <= '0;
        end
        else if (advance)
        begin
            score_reg  <= score_next;
            seen_reg   <= seen_next;
            origin_reg <= origin_next;
            run_reg    <= run_next;
            any_reg    <= any_next;
            fm_reg     <= fm_next;
            lm_reg     <= lm_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire

>>> src/window_match_density_painter_unit.sv
// ----------------------------------------------------------------------------
// window_match_density_painter_unit
// Sliding-window match density detector that paints suspect bases and
// reports a summary at the end of each alignment.
//
//   channel   signals                              direction
//   item      item_valid, item_ready, item         in  (one base per transaction)
//   result    result_valid, result_ready, result   out (paint or summary)
//   cfg       cfg_we, cfg_addr, cfg_data           in  (register write, no wait)
//
// One base is taken per cycle unless the input stalls; a base with a paint
// and a summary holds the input until its paint is taken, as the result port
// moves one transaction per cycle. A result is offered after its base passes
// the input register (with delay-memory read), then the result register.
// Reset clears control and counters; the delay memory is not cleared.
// The input stalls when the two-entry result buffer is full or cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

module window_match_density_painter_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire wmdp_pkg::item_t                     item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output wmdp_pkg::result_t                        result,
    input  wire logic                                cfg_we,
    input  wire wmdp_pkg::cfg_reg_t                  cfg_addr,
    input  wire logic [wmdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [wmdp_pkg::WS_W-1:0]           ws_cfg_reg;
    logic signed [wmdp_pkg::SCORE_W-1:0] min_score_reg;
    logic [wmdp_pkg::WS_W-1:0]           win_size;

    logic                                a_valid_reg, a_valid_next;
    wmdp_pkg::item_t                     a_item_reg;
    logic                                old_bit;

    logic                                item_fire;
    logic                                result_fire;
    logic                                res_free;
    logic                                advance;
    wmdp_pkg::step_out_t                 step;

    logic                                paint_pend_reg, paint_pend_next;
    logic                                summ_pend_reg, summ_pend_next;
    wmdp_pkg::result_t                   paint_reg;
    wmdp_pkg::result_t                   summ_reg;

    assign win_size = wmdp_pkg::eff_window(ws_cfg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_cfg_reg    <= wmdp_pkg::WINDOW_SIZE_RST;
            min_score_reg <= wmdp_pkg::MIN_SCORE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wmdp_pkg::CFG_WINDOW_SIZE: ws_cfg_reg    <= cfg_data[wmdp_pkg::WS_W-1:0];
                wmdp_pkg::CFG_MIN_SCORE:   min_score_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // result buffer empties this cycle if at most one entry is left and it drains
    assign result_valid = paint_pend_reg || summ_pend_reg;
    assign result       = paint_pend_reg ? paint_reg : summ_reg;
    assign result_fire  = result_valid && result_ready;
    assign res_free     = !(paint_pend_reg && summ_pend_reg)
                          && (!result_valid || result_ready);
    assign advance      = a_valid_reg && res_free;
    assign item_ready   = !a_valid_reg || advance;
    assign item_fire    = item_valid && item_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (item_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end

        paint_pend_next = paint_pend_reg;
        summ_pend_next  = summ_pend_reg;
        if (result_fire)
        begin
            if (paint_pend_reg)
            begin
                paint_pend_next = 1'b0;
            end
            else
            begin
                summ_pend_next = 1'b0;
            end
        end
        if (advance)
        begin
            paint_pend_next = step.paint_hit;
            summ_pend_next  = step.summ_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            paint_pend_reg <= 1'b0;
            summ_pend_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= a_valid_next;
            paint_pend_reg <= paint_pend_next;
            summ_pend_reg  <= summ_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            a_item_reg <= item;
        end
        if (advance)
        begin
            paint_reg <= step.paint;
            summ_reg  <= step.summ;
        end
    end

    wmdp_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (item_fire),
        .wr_bit   (item.is_match),
        .win_size (win_size),
        .old_bit  (old_bit)
    );

    wmdp_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (a_item_reg),
        .old_bit   (old_bit),
        .win_size  (win_size),
        .min_score (min_score_reg),
        .step      (step)
    );

endmodule

`default_nettype wire
